[hdl/mrss_pkg.sv]
package mrss_pkg;

  // encoder pulse counter width
  localparam int COUNT_WIDTH = 16;

  // item field widths
  localparam int CMD_W      = 2;
  localparam int TIME_W     = 32;
  localparam int SP_W       = 17;
  localparam int SPEED_W    = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // speed scale: (count * 10489 + 128) >> 8, 1/16 rpm
  localparam int                     SPEED_MUL_W = 14;
  localparam logic [SPEED_MUL_W-1:0] SPEED_MUL   = 14'd10489;
  localparam int                     SPEED_FRAC  = 8;
  localparam int                     ROUND_BIAS  = 128;

  // shared adder width covers the product and the 33-bit remainder plus sign
  localparam int PROD_W = COUNT_WIDTH + SPEED_MUL_W;
  localparam int ALU_W  = (PROD_W > TIME_W + 2) ? PROD_W : TIME_W + 2;

  // iteration counter
  localparam int STEP_W    = $clog2(TIME_W);
  localparam int MUL_IDX_W = $clog2(SPEED_MUL_W);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(SPEED_MUL_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(TIME_W - 1);

  // event codes
  localparam logic [CMD_W-1:0] CMD_PULSE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WINDOW = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TARGET = 2'd3;

  // setpoint source codes
  localparam logic [MODE_W-1:0] MODE_TARGET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THR = 3'd5;

  localparam logic [TIME_W-1:0]  PERIOD_RESET   = 32'd10000;
  localparam logic [SPEED_W-1:0] STOP_THR_RESET = 16'd80;

  // manual sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_RUN   = 2'd1,
    SEQ_BRAKE = 2'd2
  } seq_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_FIN
  } fsm_t;

endpackage

[hdl/mrss_evt_if.sv]
interface mrss_evt_if;
  logic                                  valid;
  logic                                  ready;
  logic [mrss_pkg::CMD_W-1:0]            cmd;
  logic [mrss_pkg::TIME_W-1:0]           time_ms;
  logic signed [mrss_pkg::SP_W-1:0]      sine_value;
  logic signed [mrss_pkg::SP_W-1:0]      target_value;

  modport source (output valid, cmd, time_ms, sine_value, target_value, input ready);
  modport sink   (input valid, cmd, time_ms, sine_value, target_value, output ready);
endinterface

[hdl/mrss_res_if.sv]
interface mrss_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mrss_pkg::SP_W-1:0]      setpoint_out;
  logic                                  forward;
  logic                                  drive_on;
  logic [mrss_pkg::SPEED_W-1:0]          speed_out;
  logic [mrss_pkg::MODE_W-1:0]           mode_out;

  modport source (output valid, setpoint_out, forward, drive_on, speed_out, mode_out,
                  input ready);
  modport sink   (input valid, setpoint_out, forward, drive_on, speed_out, mode_out,
                  output ready);
endinterface

[hdl/mrss_cfg_if.sv]
interface mrss_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [mrss_pkg::CFG_IDX_W-1:0]        index;
  logic [mrss_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/motor_reversal_setpoint_sequencer.sv]
// Motor reversal setpoint sequencer. Each event item (encoder pulse, speed
// window end, control tick, new target) yields exactly one result item with
// the setpoint, direction, drive enable, last speed and sequencer state as
// they stand after that event. One adder does all arithmetic, stepped by a
// small sequencer. A window end first runs 14 shift-add steps for the speed
// scale of 10489/256. A tick in square mode with the drive enabled first
// runs 32 restoring-division steps for time mod period and one compare
// against half the period. Pulses, targets and all other ticks go straight
// to the finish state. The block takes one item at a time; a finished
// result sits in the output register, and the next item is accepted while
// it waits. An item that finishes while the previous result is still
// waiting holds in its finish state until that result is taken. Registers
// are to be written only between items; the block does not enforce this.
module motor_reversal_setpoint_sequencer (
  input  logic       clk,
  input  logic       rst,
  mrss_evt_if.sink   evt,
  mrss_res_if.source res,
  mrss_cfg_if.sink   cfg
);
  import mrss_pkg::*;

  // configuration registers
  logic                      motor_enable;
  logic [MODE_W-1:0]         source_mode;
  logic signed [SP_W-1:0]    amp_high;
  logic signed [SP_W-1:0]    amp_low;
  logic [TIME_W-1:0]         square_period_ms;
  logic [SPEED_W-1:0]        brake_thr;

  // architectural state
  seq_t                      seq_state, seq_state_next;
  logic signed [SP_W-1:0]    setpoint_reg, setpoint_reg_next;
  logic signed [SP_W-1:0]    target_reg, target_reg_next;
  logic [COUNT_WIDTH-1:0]    enc_count, enc_count_next;
  logic [SPEED_W-1:0]        speed_reg, speed_reg_next;

  // sequencer and shared adder datapath
  fsm_t                      state, state_next;
  logic [ALU_W-1:0]          acc;      // product accumulator, then remainder
  logic [ALU_W-1:0]          opnd;     // shifted multiplicand, then divisor
  logic [TIME_W-1:0]         quo;      // dividend bits still to bring down
  logic [STEP_W-1:0]         step;
  logic [CMD_W-1:0]          cmd_q;
  logic signed [SP_W-1:0]    sine_q;
  logic signed [SP_W-1:0]    tgt_q;
  logic                      sq_high;  // square wave in its first half

  logic [ALU_W-1:0]          alu_a, alu_b, alu_y;
  logic                      alu_sub;
  logic [ALU_W-1:0]          rem_sh;
  logic                      accept, commit;

  // output register
  logic                      out_valid;
  logic signed [SP_W-1:0]    out_setpoint;
  logic                      out_forward;
  logic                      out_drive;
  logic [SPEED_W-1:0]        out_speed;
  logic [MODE_W-1:0]         out_mode;

  assign evt.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = evt.valid && evt.ready;
  assign commit    = (state == ST_FIN) && (!out_valid || res.ready);

  // the one shared adder / subtractor
  assign alu_y  = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  // remainder shifted left with the next dividend bit brought in
  assign rem_sh = {acc[ALU_W-2:0], quo[TIME_W-1]};

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_enable     <= 1'b0;
      source_mode      <= MODE_TARGET;
      amp_high         <= '0;
      amp_low          <= '0;
      square_period_ms <= PERIOD_RESET;
      brake_thr        <= STOP_THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ENABLE:   motor_enable     <= cfg.data[0];
        REG_MODE:     source_mode      <= cfg.data[MODE_W-1:0];
        REG_AMP_HIGH: amp_high         <= signed'(cfg.data[SP_W-1:0]);
        REG_AMP_LOW:  amp_low          <= signed'(cfg.data[SP_W-1:0]);
        REG_PERIOD:   square_period_ms <= cfg.data[TIME_W-1:0];
        REG_STOP_THR: brake_thr        <= cfg.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and adder operand selection
  always_comb begin
    state_next = state;
    alu_a      = acc;
    alu_b      = opnd;
    alu_sub    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (evt.cmd == CMD_WINDOW) begin
            state_next = ST_MUL;
          end else if (evt.cmd == CMD_TICK && motor_enable && source_mode == MODE_SQUARE) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        // acc += count << step where the scale bit is set
        if (step == MUL_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        alu_a   = rem_sh;
        alu_sub = 1'b1;
        if (step == DIV_LAST) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        // remainder minus half the period, sign tells the half
        alu_b      = opnd >> 1;
        alu_sub    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_q  <= evt.cmd;
          sine_q <= evt.sine_value;
          tgt_q  <= evt.target_value;
          step   <= '0;
          quo    <= evt.time_ms;
          if (evt.cmd == CMD_WINDOW) begin
            acc  <= ALU_W'(ROUND_BIAS);
            opnd <= ALU_W'(enc_count);
          end else begin
            acc  <= '0;
            // period zero acts as one
            opnd <= (square_period_ms == '0) ? ALU_W'(1) : ALU_W'(square_period_ms);
          end
        end
      end
      ST_MUL: begin
        if (SPEED_MUL[step[MUL_IDX_W-1:0]]) begin
          acc <= alu_y;
        end
        opnd <= opnd << 1;
        step <= step + STEP_W'(1);
      end
      ST_DIV: begin
        acc  <= alu_y[ALU_W-1] ? rem_sh : alu_y;
        quo  <= quo << 1;
        step <= step + STEP_W'(1);
      end
      ST_CMP: begin
        sq_high <= alu_y[ALU_W-1];
      end
      default: ;
    endcase
  end

  // effect of the held item on the architectural state
  always_comb begin
    seq_state_next    = seq_state;
    setpoint_reg_next = setpoint_reg;
    target_reg_next   = target_reg;
    enc_count_next    = enc_count;
    speed_reg_next    = speed_reg;
    case (cmd_q)
      CMD_PULSE: begin
        // saturating count
        if (enc_count != '1) begin
          enc_count_next = enc_count + COUNT_WIDTH'(1);
        end
      end
      CMD_WINDOW: begin
        if (|acc[ALU_W-1:SPEED_FRAC+SPEED_W]) begin
          speed_reg_next = '1;
        end else begin
          speed_reg_next = acc[SPEED_FRAC+SPEED_W-1:SPEED_FRAC];
        end
        enc_count_next = '0;
      end
      CMD_TICK: begin
        if (motor_enable) begin
          if (source_mode != MODE_TARGET) begin
            // sine and square sources bypass the manual machine
            seq_state_next = SEQ_RUN;
            if (source_mode == MODE_SINE) begin
              setpoint_reg_next = sine_q;
            end else if (source_mode == MODE_SQUARE) begin
              setpoint_reg_next = sq_high ? amp_high : amp_low;
            end
          end else begin
            case (seq_state)
              SEQ_RUN: begin
                // sign change or zero target: brake first
                if ((target_reg > 0 && setpoint_reg < 0) ||
                    (target_reg < 0 && setpoint_reg > 0) || target_reg == 0) begin
                  seq_state_next = SEQ_BRAKE;
                end else begin
                  setpoint_reg_next = target_reg;
                end
              end
              SEQ_BRAKE: begin
                setpoint_reg_next = '0;
                if (speed_reg < brake_thr) begin
                  seq_state_next = SEQ_IDLE;
                end
              end
              default: begin
                if (target_reg != 0) begin
                  setpoint_reg_next = target_reg;
                  seq_state_next    = SEQ_RUN;
                end
              end
            endcase
          end
        end
      end
      default: begin
        target_reg_next = tgt_q;
      end
    endcase
    // disabled: clear target and state after any event
    if (!motor_enable) begin
      seq_state_next    = SEQ_IDLE;
      setpoint_reg_next = '0;
      target_reg_next   = '0;
    end
  end

  // architectural state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= SEQ_IDLE;
      setpoint_reg <= '0;
      target_reg   <= '0;
      enc_count    <= '0;
      speed_reg    <= '0;
    end else if (commit) begin
      seq_state    <= seq_state_next;
      setpoint_reg <= setpoint_reg_next;
      target_reg   <= target_reg_next;
      enc_count    <= enc_count_next;
      speed_reg    <= speed_reg_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_setpoint <= setpoint_reg_next;
      out_forward  <= !setpoint_reg_next[SP_W-1];
      out_drive    <= motor_enable;
      out_speed    <= speed_reg_next;
      out_mode     <= seq_state_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.setpoint_out = out_setpoint;
  assign res.forward      = out_forward;
  assign res.drive_on     = out_drive;
  assign res.speed_out    = out_speed;
  assign res.mode_out     = out_mode;

`ifndef SYNTH
  // the block is never ready in the cycle after it accepts an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !evt.ready)
    else $error("ready right after an accepted item");

  // a result with the drive off shows a cleared setpoint and idle state
  a_off_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_drive) |-> (out_setpoint == '0 && out_mode == SEQ_IDLE))
    else $error("drive off but setpoint or state not cleared");

  // direction follows the setpoint sign
  a_forward_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_forward == !out_setpoint[SP_W-1]))
    else $error("forward disagrees with setpoint sign");

  // division never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (opnd != '0))
    else $error("zero divisor in square period division");

  // state only changes when a result is produced
  a_state_on_commit: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(seq_state) && $stable(target_reg))
    else $error("sequencer state changed without a result");
`endif

endmodule

[tb/sv/testbench.sv]
module testbench;
  import mrss_pkg::*;

  // undefined source mode and the two unused register slots
  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int  SETTLE_CYCLES = 48;      // longer than the longest item, a square tick
  localparam int  PULSE_RUN     = 60;      // enough for a speed far above the threshold
  localparam longint RUN_LIMIT  = 20_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [TIME_W-1:0]      t;
    logic signed [SP_W-1:0] sine;
    logic signed [SP_W-1:0] tgt;
  } motor_event_t;

  typedef struct packed {
    logic signed [SP_W-1:0] setpoint;
    logic                   fwd;
    logic                   drive;
    logic [SPEED_W-1:0]     speed;
    logic [MODE_W-1:0]      seq;
  } drive_status_t;

  logic clk;
  logic rst;

  mrss_evt_if evt_if ();
  mrss_res_if res_if ();
  mrss_cfg_if cfg_if ();

  motor_reversal_setpoint_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt_if.sink),
    .res (res_if.source),
    .cfg (cfg_if.sink)
  );

  // shadow of the configuration registers
  logic                   en_r;
  logic [MODE_W-1:0]      mode_r;
  logic signed [SP_W-1:0] amp_hi_r;
  logic signed [SP_W-1:0] amp_lo_r;
  logic [TIME_W-1:0]      period_r;
  logic [SPEED_W-1:0]     thr_r;

  // shadow of the block's own state
  seq_t                   seq_r;
  logic signed [SP_W-1:0] sp_r;
  logic signed [SP_W-1:0] tgt_r;
  logic [COUNT_WIDTH-1:0] pulses_r;
  logic [SPEED_W-1:0]     speed_r;

  motor_event_t  event_backlog[$];     // items waiting to be sent
  drive_status_t status_due[$];        // predicted results, oldest first
  int unsigned   queued_items;
  int unsigned   accepted_items;
  int unsigned   errors;
  int unsigned   checked;
  bit            quiet;                // no gaps, no stalls

  // sender burst/gap bookkeeping
  int unsigned   burst_left;
  int unsigned   gap_left;
  motor_event_t  next_item;

  // receiver stall pattern
  int unsigned   stall_tick;
  int unsigned   stall_style;
  int unsigned   hold_cnt;
  drive_status_t due;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // configuration register write, as the block applies it
  task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_ENABLE:   en_r = d[0];
      REG_MODE:     mode_r = d[MODE_W-1:0];
      REG_AMP_HIGH: amp_hi_r = d[SP_W-1:0];
      REG_AMP_LOW:  amp_lo_r = d[SP_W-1:0];
      REG_PERIOD:   period_r = d[TIME_W-1:0];
      REG_STOP_THR: thr_r = d[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // next state of the sequencer for one event, and what the block reports after it
  function automatic drive_status_t sequencer_next(input motor_event_t it);
    drive_status_t r;
    logic [63:0]       scaled;
    logic [TIME_W-1:0] p;
    case (it.cmd)
      CMD_PULSE: begin
        // counter saturates at its top
        if (pulses_r != {COUNT_WIDTH{1'b1}}) pulses_r = pulses_r + COUNT_WIDTH'(1);
      end
      CMD_WINDOW: begin
        scaled = (64'(pulses_r) * 64'(SPEED_MUL) + 64'(ROUND_BIAS)) >> SPEED_FRAC;
        speed_r = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[SPEED_W-1:0];
        pulses_r = '0;
      end
      CMD_TICK: begin
        if (en_r) begin
          if (mode_r == MODE_TARGET) begin
            case (seq_r)
              SEQ_RUN: begin
                // direction change or zero target: brake first
                if ((tgt_r > 0 && sp_r < 0) || (tgt_r < 0 && sp_r > 0) || tgt_r == 0)
                  seq_r = SEQ_BRAKE;
                else
                  sp_r = tgt_r;
              end
              SEQ_BRAKE: begin
                sp_r = '0;
                if (speed_r < thr_r) seq_r = SEQ_IDLE;
              end
              default: begin
                if (tgt_r != 0) begin
                  sp_r = tgt_r;
                  seq_r = SEQ_RUN;
                end
              end
            endcase
          end else begin
            seq_r = SEQ_RUN;
            if (mode_r == MODE_SINE) begin
              sp_r = it.sine;
            end else if (mode_r == MODE_SQUARE) begin
              p = (period_r == '0) ? 32'd1 : period_r;
              sp_r = ((it.t % p) < (p / 32'd2)) ? amp_hi_r : amp_lo_r;
            end
            // undefined mode holds the setpoint
          end
        end
      end
      default: tgt_r = it.tgt;
    endcase
    if (!en_r) begin
      seq_r = SEQ_IDLE;
      sp_r = '0;
      tgt_r = '0;
    end
    r.setpoint = sp_r;
    r.fwd = (sp_r >= 0);
    r.drive = en_r;
    r.speed = speed_r;
    r.seq = seq_r;
    return r;
  endfunction

  // driver: bursts of items from the backlog, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      evt_if.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        status_due.push_back(sequencer_next({evt_if.cmd, evt_if.time_ms,
                                             evt_if.sine_value, evt_if.target_value}));
        accepted_items++;
      end
      if (!evt_if.valid || evt_if.ready) begin
        if (gap_left > 0 && !quiet) begin
          gap_left--;
          evt_if.valid <= 1'b0;
        end else if (event_backlog.size() > 0) begin
          next_item = event_backlog.pop_front();
          evt_if.valid        <= 1'b1;
          evt_if.cmd          <= next_item.cmd;
          evt_if.time_ms      <= next_item.t;
          evt_if.sine_value   <= next_item.sine;
          evt_if.target_value <= next_item.tgt;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 7);
          end
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item, and drive ready on a stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_tick = 0;
      stall_style = 0;
      hold_cnt = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        checked++;
        if (status_due.size() == 0) begin
          if (errors < 10) begin
            $display("result %0d arrived with nothing predicted:", checked);
            $display("  sp=%0d fwd=%b drv=%b spd=%0d st=%0d",
                     res_if.setpoint_out, res_if.forward, res_if.drive_on,
                     res_if.speed_out, res_if.mode_out);
          end
          errors++;
        end else begin
          due = status_due.pop_front();
          if (res_if.setpoint_out !== due.setpoint || res_if.forward !== due.fwd ||
              res_if.drive_on !== due.drive || res_if.speed_out !== due.speed ||
              res_if.mode_out !== due.seq) begin
            if (errors < 10) begin
              $display("result %0d: exp sp=%0d fwd=%b drv=%b spd=%0d st=%0d",
                       checked, due.setpoint, due.fwd, due.drive, due.speed, due.seq);
              $display("  got sp=%0d fwd=%b drv=%b spd=%0d st=%0d",
                       res_if.setpoint_out, res_if.forward, res_if.drive_on,
                       res_if.speed_out, res_if.mode_out);
            end
            errors++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 3);
      if (quiet || stall_style == 0) begin
        res_if.ready <= 1'b1;
      end else if (stall_style == 1) begin
        res_if.ready <= (stall_tick % 3 != 0);
      end else if (stall_style == 2) begin
        res_if.ready <= 1'($urandom_range(0, 1));
      end else begin
        // long stalls with one ready cycle between
        if (hold_cnt > 0) begin
          hold_cnt--;
          res_if.ready <= 1'b0;
        end else begin
          hold_cnt = $urandom_range(1, 12);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic queue_item(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                            input logic signed [SP_W-1:0] s, input logic signed [SP_W-1:0] g);
    event_backlog.push_back({c, t, s, g});
    queued_items++;
  endtask

  // wait for every item to be taken and answered, then let the block settle
  task automatic settle();
    while (!(accepted_items == queued_items && status_due.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    shadow_write(idx, d);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic reconfigure(input logic en, input logic [MODE_W-1:0] m,
                             input logic signed [SP_W-1:0] hi, input logic signed [SP_W-1:0] lo,
                             input logic [TIME_W-1:0] per, input logic [SPEED_W-1:0] thr);
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_AMP_HIGH, {{(CFG_DATA_W-SP_W){hi[SP_W-1]}}, hi});
    write_reg(REG_AMP_LOW, {{(CFG_DATA_W-SP_W){lo[SP_W-1]}}, lo});
    write_reg(REG_PERIOD, per);
    write_reg(REG_STOP_THR, 32'(thr));
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [SP_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return -17'sd65536;
      1: return 17'sd65535;
      2: return '0;
      3, 4: return 17'($signed($urandom_range(0, 4000)) - 2000);
      default: return 17'($urandom);
    endcase
  endfunction

  // mostly well-formed sequences: pulse runs closed by a window, targets
  // followed by ticks, tick runs that let braking finish; some noise
  task automatic traffic(input int n);
    int made;
    int k;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          k = $urandom_range(0, 48);
          repeat (k) queue_item(CMD_PULSE, $urandom, 17'($urandom), 17'($urandom));
          queue_item(CMD_WINDOW, $urandom, 17'($urandom), 17'($urandom));
          made += k + 1;
        end
        3, 4: begin
          k = $urandom_range(1, 4);
          queue_item(CMD_TARGET, $urandom, 17'($urandom), pick_target());
          repeat (k) queue_item(CMD_TICK, pick_time(), 17'($urandom), 17'($urandom));
          made += k + 1;
        end
        5, 6: begin
          k = $urandom_range(1, 6);
          repeat (k) queue_item(CMD_TICK, pick_time(), 17'($urandom), 17'($urandom));
          made += k;
        end
        7: begin
          queue_item(CMD_TARGET, $urandom, 17'($urandom), '0);
          queue_item(CMD_TICK, pick_time(), 17'($urandom), 17'($urandom));
          made += 2;
        end
        default: begin
          queue_item(2'($urandom), $urandom, 17'($urandom), 17'($urandom));
          made += 1;
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    queued_items = 0;
    accepted_items = 0;
    errors = 0;
    checked = 0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_ENABLE;
    cfg_if.data <= '0;

    // shadow starts from the reset values
    en_r = 1'b0;
    mode_r = MODE_TARGET;
    amp_hi_r = '0;
    amp_lo_r = '0;
    period_r = PERIOD_RESET;
    thr_r = STOP_THR_RESET;
    seq_r = SEQ_IDLE;
    sp_r = '0;
    tgt_r = '0;
    pulses_r = '0;
    speed_r = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // disabled: a target is dropped at once, ticks do nothing
    queue_item(CMD_TARGET, '0, '0, 17'sd65535);
    queue_item(CMD_TICK, '0, 17'sd1234, '0);
    queue_item(CMD_PULSE, '0, '0, '0);
    settle();

    // unused register slots are ignored
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, STOP_THR_RESET);

    // manual machine walk: start, hold, reversal through braking, stop
    queue_item(CMD_WINDOW, '0, '0, '0);              // the one pulse above, speed 41
    queue_item(CMD_PULSE, '0, '0, '0);
    queue_item(CMD_PULSE, '0, '0, '0);
    queue_item(CMD_WINDOW, '0, '0, '0);              // speed 82, above threshold
    queue_item(CMD_TARGET, '0, '0, 17'sd1000);
    queue_item(CMD_TICK, '0, '0, '0);                // idle to running
    queue_item(CMD_TICK, '0, '0, '0);                // same target holds
    queue_item(CMD_TARGET, '0, '0, -17'sd1000);
    queue_item(CMD_TICK, '0, '0, '0);                // reversal: brake
    queue_item(CMD_TICK, '0, '0, '0);                // still too fast
    queue_item(CMD_WINDOW, '0, '0, '0);              // speed 0
    queue_item(CMD_TICK, '0, '0, '0);                // stopped: idle
    queue_item(CMD_TICK, '0, '0, '0);                // idle to running, reverse
    queue_item(CMD_TARGET, '0, '0, -17'sd65536);
    queue_item(CMD_TICK, '0, '0, '0);                // same sign, follow
    queue_item(CMD_TARGET, '0, '0, '0);
    queue_item(CMD_TICK, '0, '0, '0);                // zero target: brake
    queue_item(CMD_TICK, '0, '0, '0);                // stopped: idle
    queue_item(CMD_TICK, 32'hFFFF_FFFF, -17'sd65536, 17'sd65535);  // idle, no target
    settle();

    // manual mode across thresholds: the reset value, the extremes, then a random one
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, STOP_THR_RESET);
    traffic(110);
    settle();
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, 16'd0);      // brake never ends
    traffic(110);
    settle();
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, 16'hFFFF);
    traffic(110);
    settle();
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, 16'($urandom_range(0, 3000)));
    traffic(110);
    settle();

    // sine pass-through
    reconfigure(1'b1, MODE_SINE, '0, '0, PERIOD_RESET, STOP_THR_RESET);
    traffic(110);
    settle();

    // square wave: shortest legal period, periods below two, longest, small ones
    reconfigure(1'b1, MODE_SQUARE, 17'sd65535, -17'sd65536, 32'd2, STOP_THR_RESET);
    traffic(110);
    settle();
    reconfigure(1'b1, MODE_SQUARE, 17'($urandom), 17'($urandom), 32'd0, STOP_THR_RESET);
    traffic(90);
    settle();
    reconfigure(1'b1, MODE_SQUARE, 17'($urandom), 17'($urandom), 32'd1, STOP_THR_RESET);
    traffic(90);
    settle();
    reconfigure(1'b1, MODE_SQUARE, -17'sd65536, 17'sd65535, 32'hFFFF_FFFF, 16'($urandom));
    traffic(110);
    settle();
    reconfigure(1'b1, MODE_SQUARE, 17'($urandom), 17'($urandom),
                32'($urandom_range(2, 50)), 16'($urandom));
    traffic(110);
    settle();

    // undefined mode holds the setpoint left by the square wave
    reconfigure(1'b1, MODE_SPARE, 17'($urandom), 17'($urandom), $urandom, 16'($urandom));
    traffic(90);
    settle();

    // disabled with a source still selected
    reconfigure(1'b0, 2'($urandom), 17'($urandom), 17'($urandom), $urandom, 16'($urandom));
    traffic(80);
    settle();

    // back to manual with the machine left running by another source
    reconfigure(1'b1, MODE_SINE, '0, '0, PERIOD_RESET, STOP_THR_RESET);
    traffic(40);
    settle();
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, 16'($urandom_range(0, 2000)));
    traffic(110);
    settle();

    // fully random settings
    repeat (3) begin
      reconfigure(($urandom_range(0, 3) != 0), 2'($urandom), 17'($urandom), 17'($urandom),
                  ($urandom_range(0, 1) ? 32'($urandom_range(0, 60)) : 32'($urandom)),
                  16'($urandom));
      traffic(90);
      settle();
    end

    // long pulse run, then a high speed that keeps braking going, then a stop
    reconfigure(1'b1, MODE_TARGET, '0, '0, PERIOD_RESET, STOP_THR_RESET);
    quiet = 1'b1;
    queue_item(CMD_TARGET, '0, '0, 17'sd500);
    queue_item(CMD_TICK, '0, '0, '0);
    repeat (PULSE_RUN) queue_item(CMD_PULSE, $urandom, 17'($urandom), 17'($urandom));
    queue_item(CMD_WINDOW, '0, '0, '0);
    queue_item(CMD_TARGET, '0, '0, '0);
    queue_item(CMD_TICK, '0, '0, '0);
    queue_item(CMD_TICK, '0, '0, '0);                // speed far above threshold, still braking
    queue_item(CMD_WINDOW, '0, '0, '0);
    queue_item(CMD_TICK, '0, '0, '0);
    settle();
    quiet = 1'b0;

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
